FILE: hdl/c2isa_pkg.sv
// ----------------------------------------------------------------------------
// c2isa_pkg
// Shared types, widths and codes of the col2im scatter-accumulate block.
// ----------------------------------------------------------------------------
package c2isa_pkg;

  // Default store geometry
  localparam int unsigned MaxDim      = 32;
  localparam int unsigned MaxChannels = 16;

  // Field widths
  localparam int unsigned ValW   = 32;
  localparam int unsigned RAddrW = 14;
  localparam int unsigned KernW  = 4;
  localparam int unsigned ChW    = 4;
  localparam int unsigned GPosW  = 5;
  localparam int unsigned StatW  = 2;

  // Configuration register widths
  localparam int unsigned StrideW = 3;
  localparam int unsigned PadW    = 3;
  localparam int unsigned KsW     = 4;
  localparam int unsigned DimW    = 6;
  localparam int unsigned ChCfgW  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 6;

  // Internal widths: signed image position, row-major pixel index, entry index
  localparam int unsigned PosW = 10;
  localparam int unsigned LinW = 12;
  localparam int unsigned IdxW = 17;

  // Work queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;

  // Item kinds
  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STRIDE       = 3'd0,
    REG_PAD          = 3'd1,
    REG_KERNEL_SIZE  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_CHANNELS_IN  = 3'd5,
    REG_GRAD_HEIGHT  = 3'd6,
    REG_GRAD_WIDTH   = 3'd7
  } cfg_reg_e;

  typedef enum logic [StatW-1:0] {
    STAT_ADDED   = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_READ    = 2'd2
  } status_e;

  // Operation handed to the back end
  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_DROP     = 2'd1,
    OP_READ     = 2'd2,
    OP_READ_OOR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_EXEC  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [StrideW-1:0] stride;
    logic [PadW-1:0]    pad;
    logic [KsW-1:0]     kernel_size;
    logic [DimW-1:0]    image_height;
    logic [DimW-1:0]    image_width;
    logic [ChCfgW-1:0]  channels_in;
    logic [DimW-1:0]    grad_height;
    logic [DimW-1:0]    grad_width;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    stride:       3'd1,
    pad:          3'd0,
    kernel_size:  4'd3,
    image_height: 6'd32,
    image_width:  6'd32,
    channels_in:  5'd16,
    grad_height:  6'd32,
    grad_width:   6'd32
  };

  typedef struct packed {
    op_e                    op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] value;
  } q_entry_t;

endpackage

FILE: hdl/c2isa_if.sv
// ----------------------------------------------------------------------------
// c2isa_if
// Valid/ready channels for command items in and result items out.
// ----------------------------------------------------------------------------
interface c2isa_in_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [3:0]        kernel_row;
  logic [3:0]        kernel_col;
  logic [3:0]        channel;
  logic [4:0]        out_row;
  logic [4:0]        out_col;
  logic signed [31:0] value;
  logic [13:0]       read_address;

  modport source (
    output valid, cmd, kernel_row, kernel_col, channel, out_row, out_col, value,
           read_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, kernel_row, kernel_col, channel, out_row, out_col, value,
           read_address,
    output ready
  );
endinterface

interface c2isa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic               saturated;

  modport source (
    output valid, status, read_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, status, read_value, saturated,
    output ready
  );
endinterface

FILE: hdl/c2isa_queue.sv
// ----------------------------------------------------------------------------
// c2isa_queue
// Short FIFO of decoded operations between the front and the back end.
// ----------------------------------------------------------------------------
module c2isa_queue import c2isa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     push_ready_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output q_entry_t head_o
);

  q_entry_t         slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

FILE: hdl/c2isa_front.sv
// ----------------------------------------------------------------------------
// c2isa_front
// Accepts items, maps kernel/gradient offsets to a store entry and classifies
// each item as add, drop or read in two register stages.
// ----------------------------------------------------------------------------
module c2isa_front import c2isa_pkg::*; #(
  parameter int unsigned MAX_DIM      = MaxDim,
  parameter int unsigned MAX_CHANNELS = MaxChannels
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         hold_i,
  c2isa_in_if.sink     in_if,
  output logic         push_valid_o,
  output q_entry_t     push_entry_o,
  input  logic         push_ready_i
);

  localparam int unsigned StoreDepth = MAX_DIM * MAX_DIM * MAX_CHANNELS;

  typedef struct packed {
    logic                   cmd;
    logic                   ok;
    logic [PosW-1:0]        row;
    logic [PosW-1:0]        col;
    logic [ChW-1:0]         ch;
    logic signed [ValW-1:0] value;
    logic [RAddrW-1:0]      raddr;
  } s1_t;

  typedef struct packed {
    logic                   cmd;
    logic                   ok;
    logic [LinW-1:0]        lin;
    logic [ChW-1:0]         ch;
    logic signed [ValW-1:0] value;
    logic [RAddrW-1:0]      raddr;
  } s2_t;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic s1_v_q, s2_v_q;
  logic adv, accept;
  logic [7:0] rprod, cprod;
  logic in_img;
  logic [IdxW-1:0] idx;
  logic idx_ok, raddr_ok;

  // Whole pipeline moves when the last stage is empty or drains into the queue
  assign adv         = !s2_v_q || push_ready_i;
  assign in_if.ready = adv && !hold_i;
  assign accept      = in_if.valid && in_if.ready;

  // Stage 1: offset checks and image row/column (two's complement, wraps)
  always_comb begin
    rprod = 8'(in_if.out_row * cfg_i.stride);
    cprod = 8'(in_if.out_col * cfg_i.stride);
    s1_d.cmd   = in_if.cmd;
    s1_d.ok    = (in_if.kernel_row < cfg_i.kernel_size) &&
                 (in_if.kernel_col < cfg_i.kernel_size) &&
                 (ChCfgW'(in_if.channel) < cfg_i.channels_in) &&
                 (DimW'(in_if.out_row) < cfg_i.grad_height) &&
                 (DimW'(in_if.out_col) < cfg_i.grad_width);
    s1_d.row   = PosW'(in_if.kernel_row) + PosW'(rprod) - PosW'(cfg_i.pad);
    s1_d.col   = PosW'(in_if.kernel_col) + PosW'(cprod) - PosW'(cfg_i.pad);
    s1_d.ch    = in_if.channel;
    s1_d.value = in_if.value;
    s1_d.raddr = in_if.read_address;
  end

  // Stage 2: image bounds and row-major pixel index
  always_comb begin
    in_img = !s1_q.row[PosW-1] && !s1_q.col[PosW-1] &&
             (s1_q.row < PosW'(cfg_i.image_height)) &&
             (s1_q.col < PosW'(cfg_i.image_width));
    s2_d.cmd   = s1_q.cmd;
    s2_d.ok    = s1_q.ok && in_img;
    s2_d.lin   = LinW'(s1_q.row[DimW-1:0]) * LinW'(cfg_i.image_width) +
                 LinW'(s1_q.col[DimW-1:0]);
    s2_d.ch    = s1_q.ch;
    s2_d.value = s1_q.value;
    s2_d.raddr = s1_q.raddr;
  end

  // Stage 3: channel interleave and classification into the queue
  always_comb begin
    idx      = IdxW'(s2_q.lin) * IdxW'(cfg_i.channels_in) + IdxW'(s2_q.ch);
    idx_ok   = 32'(idx) < 32'(StoreDepth);
    raddr_ok = 32'(s2_q.raddr) < 32'(StoreDepth);
    push_entry_o.value = s2_q.value;
    if (s2_q.cmd == CMD_READ) begin
      push_entry_o.op  = raddr_ok ? OP_READ : OP_READ_OOR;
      push_entry_o.idx = IdxW'(s2_q.raddr);
    end else begin
      push_entry_o.op  = (s2_q.ok && idx_ok) ? OP_ADD : OP_DROP;
      push_entry_o.idx = idx;
    end
  end

  assign push_valid_o = s2_v_q;

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule

FILE: hdl/c2isa_back.sv
// ----------------------------------------------------------------------------
// c2isa_back
// Owns the image store: clears it after reset, then performs read-modify-write
// adds with saturation and read-and-clear, and holds the result register.
// ----------------------------------------------------------------------------
module c2isa_back import c2isa_pkg::*; #(
  parameter int unsigned MAX_DIM      = MaxDim,
  parameter int unsigned MAX_CHANNELS = MaxChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  q_entry_t   head_i,
  output logic       pop_o,
  output logic       clearing_o,
  c2isa_out_if.source out_if
);

  localparam int unsigned StoreDepth = MAX_DIM * MAX_DIM * MAX_CHANNELS;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic signed [ValW-1:0] store_mem [StoreDepth];
  logic signed [ValW-1:0] rd_q;

  back_state_e state_q, state_d;
  q_entry_t    cur_q, cur_d;
  logic [AddrW-1:0] clr_q, clr_d;

  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_addr;
  logic signed [ValW-1:0] mem_wdata;

  logic                   out_v_q, load;
  status_e                stat_q, stat_d;
  logic signed [ValW-1:0] rval_q, rval_d;
  logic                   sat_q, sat_d;
  logic                   slot_free;

  logic signed [ValW:0]   sum;
  logic                   ovf;
  logic signed [ValW-1:0] sat_sum;

  // Saturating add of the stored entry and the element
  always_comb begin
    sum     = {rd_q[ValW-1], rd_q} + {cur_q.value[ValW-1], cur_q.value};
    ovf     = sum[ValW] != sum[ValW-1];
    sat_sum = ovf ? {sum[ValW], {(ValW-1){~sum[ValW]}}} : sum[ValW-1:0];
  end

  assign slot_free  = !out_v_q || out_if.ready;
  assign clearing_o = (state_q == BK_CLEAR);

  // Sequencer: next state, store access and result load
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AddrW'(head_i.idx);
    mem_wdata = '0;
    pop_o     = 1'b0;
    load      = 1'b0;
    stat_d    = stat_q;
    rval_d    = rval_q;
    sat_d     = sat_q;
    case (state_q)
      BK_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AddrW'(StoreDepth - 1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (head_valid_i && slot_free) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_ADD, OP_READ: begin
              mem_re  = 1'b1;
              cur_d   = head_i;
              state_d = BK_EXEC;
            end
            OP_DROP: begin
              load   = 1'b1;
              stat_d = STAT_DROPPED;
              rval_d = '0;
              sat_d  = 1'b0;
            end
            default: begin
              // read beyond the store: nothing to clear
              load   = 1'b1;
              stat_d = STAT_READ;
              rval_d = '0;
              sat_d  = 1'b0;
            end
          endcase
        end
      end
      BK_EXEC: begin
        mem_we   = 1'b1;
        mem_addr = AddrW'(cur_q.idx);
        load     = 1'b1;
        state_d  = BK_IDLE;
        if (cur_q.op == OP_READ) begin
          mem_wdata = '0;
          stat_d    = STAT_READ;
          rval_d    = rd_q;
          sat_d     = 1'b0;
        end else begin
          mem_wdata = sat_sum;
          stat_d    = STAT_ADDED;
          rval_d    = '0;
          sat_d     = ovf;
        end
      end
      default: state_d = BK_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load)              out_v_q <= 1'b1;
      else if (out_if.ready) out_v_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      stat_q <= stat_d;
      rval_q <= rval_d;
      sat_q  <= sat_d;
    end
  end

  // Image store, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= store_mem[mem_addr];
  end

  assign out_if.valid      = out_v_q;
  assign out_if.status     = stat_q;
  assign out_if.read_value = rval_q;
  assign out_if.saturated  = sat_q;

endmodule

FILE: hdl/col2im_scatter_accumulate.sv
// ----------------------------------------------------------------------------
// col2im_scatter_accumulate
// col2im scatter-accumulate of Q16.16 column elements into an NHWC store.
// ----------------------------------------------------------------------------
// Each accumulate item adds one column-matrix element into the image store
// entry ((kernel_row + out_row*stride - pad)*image_width + kernel_col +
// out_col*stride - pad)*channels_in + channel, saturating to 32 bits; items
// falling outside the image or with out-of-range offsets are dropped. A read
// item returns one entry and clears it. Every item yields exactly one result.
// After reset the store is cleared one entry per cycle, all MAX_DIM*MAX_DIM*
// MAX_CHANNELS entries (16384 by default), with the input held off; config
// writes are taken throughout. The front end takes one item per cycle, while
// the queue has room, into a two-stage address pipeline and a four-entry
// queue; the back end, bound by the single store port, does each add or
// in-range read as a store read then a write back, takes no new item until
// both are done, and settles a dropped item or read beyond the store without
// a store access. A result passes the two address stages and the queue, and
// for an add or in-range read the execute state, before the result register;
// it also waits while earlier items fill the queue or the output is stalled.
// ----------------------------------------------------------------------------
module col2im_scatter_accumulate import c2isa_pkg::*; #(
  parameter int unsigned MAX_DIM      = MaxDim,
  parameter int unsigned MAX_CHANNELS = MaxChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  c2isa_in_if.sink           in_if,
  c2isa_out_if.source        out_if
);

  cfg_t     cfg_q, cfg_d;
  logic     clearing;
  logic     push_valid, push_ready, pop, head_valid;
  q_entry_t push_entry, head;

  // Configuration register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_STRIDE:       cfg_d.stride       = cfg_data_i[StrideW-1:0];
        REG_PAD:          cfg_d.pad          = cfg_data_i[PadW-1:0];
        REG_KERNEL_SIZE:  cfg_d.kernel_size  = cfg_data_i[KsW-1:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = cfg_data_i[DimW-1:0];
        REG_IMAGE_WIDTH:  cfg_d.image_width  = cfg_data_i[DimW-1:0];
        REG_CHANNELS_IN:  cfg_d.channels_in  = cfg_data_i[ChCfgW-1:0];
        REG_GRAD_HEIGHT:  cfg_d.grad_height  = cfg_data_i[DimW-1:0];
        REG_GRAD_WIDTH:   cfg_d.grad_width   = cfg_data_i[DimW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  c2isa_front #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .hold_i       (clearing),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  c2isa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  c2isa_back #(
    .MAX_DIM      (MAX_DIM),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_if       (out_if)
  );

endmodule

FILE: hdl/c2isa_checker.sv
// ----------------------------------------------------------------------------
// c2isa_checker
// Port-level checks of the scatter-accumulate block, bound to the top level.
// ----------------------------------------------------------------------------
module c2isa_checker import c2isa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [StatW-1:0] out_status_i,
  input logic [ValW-1:0]  out_read_value_i,
  input logic             out_saturated_i
);

  // Store is being cleared in the cycle after reset: no item taken
  a_no_accept_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i)
    else $error("item accepted during store clearing");

  // Only reads carry data
  a_read_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STAT_READ) |-> out_read_value_i == '0)
    else $error("non-read result carries a value");

  // Only adds can clip
  a_sat_only_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_saturated_i |-> out_status_i == STAT_ADDED)
    else $error("saturation flagged on a non-add result");

  // A waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result withdrawn before it was taken");

endmodule

bind col2im_scatter_accumulate c2isa_checker u_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_status_i     (out_if.status),
  .out_read_value_i (out_if.read_value),
  .out_saturated_i  (out_if.saturated)
);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the col2im scatter-accumulate block.
// ----------------------------------------------------------------------------
// Keeps its own copy of the image store and register set and works out the
// result of every accepted item. A short table of hand-made items comes
// first; some rows carry a typed-in answer, the rest are worked out. Random
// phases under different register settings follow, with the sender and the
// receiver idling at different rates. Each result item is checked field by
// field against the oldest outstanding answer, in order.
// ----------------------------------------------------------------------------
module testbench;
  import c2isa_pkg::*;

  localparam int StoreDepth   = MaxDim * MaxDim * MaxChannels;
  localparam int CycleLimit   = 200_000;
  localparam int DrainCycles  = 16;
  localparam int NumRegs      = 8;
  localparam int NumDirected  = 21;
  localparam int NumPhases    = 8;

  typedef struct packed {
    logic                   cmd;
    logic [KernW-1:0]       kernel_row;
    logic [KernW-1:0]       kernel_col;
    logic [ChW-1:0]         channel;
    logic [GPosW-1:0]       out_row;
    logic [GPosW-1:0]       out_col;
    logic signed [ValW-1:0] value;
    logic [RAddrW-1:0]      read_address;
  } cmd_item_t;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] read_value;
    logic                   saturated;
  } reply_t;

  typedef struct packed {
    cmd_item_t item;
    logic      typed_in;
    reply_t    reply;
  } directed_row_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Hand-made items at the reset settings (stride 1, pad 0, 3x3, 32x32x16)
  localparam directed_row_t DirectedRows [NumDirected] = '{
    // empty store, lowest and highest entry
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd0}, 1'b1,
      '{STAT_READ, 32'h0, 1'b0}},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd16383}, 1'b1,
      '{STAT_READ, 32'h0, 1'b0}},
    // positive saturation at entry 0, read back, read again after clearing
    '{'{CMD_ACC, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h7FFF_FFFF, 14'd0}, 1'b1,
      '{STAT_ADDED, 32'h0, 1'b0}},
    '{'{CMD_ACC, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0000_0001, 14'd0}, 1'b1,
      '{STAT_ADDED, 32'h0, 1'b1}},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd0}, 1'b1,
      '{STAT_READ, 32'h7FFF_FFFF, 1'b0}},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd0}, 1'b1,
      '{STAT_READ, 32'h0, 1'b0}},
    // negative saturation
    '{'{CMD_ACC, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h8000_0000, 14'd0}, 1'b1,
      '{STAT_ADDED, 32'h0, 1'b0}},
    '{'{CMD_ACC, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'hFFFF_FFFF, 14'd0}, 1'b1,
      '{STAT_ADDED, 32'h0, 1'b1}},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd0}, 1'b1,
      '{STAT_READ, 32'h8000_0000, 1'b0}},
    // kernel offsets beyond the filter size
    '{'{CMD_ACC, 4'd3, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0001_0000, 14'd0}, 1'b1,
      '{STAT_DROPPED, 32'h0, 1'b0}},
    '{'{CMD_ACC, 4'd0, 4'd15, 4'd0, 5'd0, 5'd0, 32'h0001_0000, 14'd0}, 1'b1,
      '{STAT_DROPPED, 32'h0, 1'b0}},
    '{'{CMD_ACC, 4'd14, 4'd14, 4'd15, 5'd31, 5'd31, 32'hFFFF_FFFF, 14'h3FFF}, 1'b1,
      '{STAT_DROPPED, 32'h0, 1'b0}},
    // last entry of the store, then read back
    '{'{CMD_ACC, 4'd2, 4'd2, 4'd15, 5'd29, 5'd29, 32'h1234_5678, 14'd0}, 1'b1,
      '{STAT_ADDED, 32'h0, 1'b0}},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd16383}, 1'b1,
      '{STAT_READ, 32'h1234_5678, 1'b0}},
    // row and column past the image edge
    '{'{CMD_ACC, 4'd1, 4'd0, 4'd0, 5'd31, 5'd0, 32'h0000_0001, 14'd0}, 1'b1,
      '{STAT_DROPPED, 32'h0, 1'b0}},
    '{'{CMD_ACC, 4'd0, 4'd2, 4'd0, 5'd0, 5'd31, 32'h0000_0001, 14'd0}, 1'b1,
      '{STAT_DROPPED, 32'h0, 1'b0}},
    // two column elements landing on one entry (row 11, col 9, channel 5)
    '{'{CMD_ACC, 4'd1, 4'd2, 4'd5, 5'd10, 5'd7, 32'h0001_0000, 14'd0}, 1'b0,
      '0},
    '{'{CMD_ACC, 4'd0, 4'd1, 4'd5, 5'd11, 5'd8, 32'hFFFF_8000, 14'd0}, 1'b0,
      '0},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'd5781}, 1'b0, '0},
    '{'{CMD_READ, 4'd15, 4'd15, 4'd15, 5'd31, 5'd31, 32'hFFFF_FFFF, 14'h2AAA}, 1'b0,
      '0},
    '{'{CMD_READ, 4'd0, 4'd0, 4'd0, 5'd0, 5'd0, 32'h0, 14'h1555}, 1'b0, '0}
  };

  // Register values per phase, in register index order:
  // stride, pad, kernel_size, image_height, image_width, channels_in,
  // grad_height, grad_width
  localparam logic [CfgW-1:0] PhaseRegs [NumPhases][NumRegs] = '{
    '{6'd1, 6'd0, 6'd3, 6'd32, 6'd32, 6'd16, 6'd32, 6'd32},
    '{6'd2, 6'd1, 6'd3, 6'd8, 6'd8, 6'd4, 6'd4, 6'd4},
    '{6'd0, 6'd3, 6'd5, 6'd6, 6'd5, 6'd3, 6'd7, 6'd9},
    '{6'd4, 6'd7, 6'd15, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1},
    '{6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F},
    '{6'd3, 6'd2, 6'd7, 6'd16, 6'd12, 6'd16, 6'd32, 6'd32},
    '{6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0},
    '{6'd1, 6'd0, 6'd1, 6'd4, 6'd4, 6'd2, 6'd4, 6'd4}
  };
  localparam int PhaseItems [NumPhases] = '{200, 250, 150, 100, 150, 250, 50, 100};
  localparam idle_mode_e PhaseIdle [NumPhases] = '{
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  };

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  c2isa_in_if  item_ch ();
  c2isa_out_if reply_ch ();

  // Own copy of the registers and the image store
  cfg_t                   regs_copy;
  logic signed [ValW-1:0] image_copy [StoreDepth];
  reply_t                 replies_due [$];
  reply_t                 oldest_due;

  int sender_idle_pct;
  int receiver_stall_pct;
  int mismatches;
  int cycles;

  col2im_scatter_accumulate u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_if       (item_ch),
    .out_if      (reply_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Scatter one item into the image copy and return the reply it earns
  function automatic reply_t scatter_item(cmd_item_t it);
    reply_t  res;
    int      row;
    int      col;
    longint  idx;
    longint  sum;
    logic    in_image;

    res = '0;
    if (it.cmd == CMD_READ) begin
      res.status = STAT_READ;
      if (int'(it.read_address) < StoreDepth) begin
        res.read_value = image_copy[it.read_address];
        image_copy[it.read_address] = '0;
      end
      return res;
    end

    row = int'(it.kernel_row) + int'(it.out_row) * int'(regs_copy.stride)
          - int'(regs_copy.pad);
    col = int'(it.kernel_col) + int'(it.out_col) * int'(regs_copy.stride)
          - int'(regs_copy.pad);
    in_image = (it.kernel_row < regs_copy.kernel_size)
            && (it.kernel_col < regs_copy.kernel_size)
            && (it.channel < regs_copy.channels_in)
            && (it.out_row < regs_copy.grad_height)
            && (it.out_col < regs_copy.grad_width)
            && (row >= 0) && (col >= 0)
            && (row < int'(regs_copy.image_height))
            && (col < int'(regs_copy.image_width));
    idx = (longint'(row) * longint'(regs_copy.image_width) + longint'(col))
          * longint'(regs_copy.channels_in) + longint'(it.channel);
    if (!in_image || idx >= StoreDepth) begin
      res.status = STAT_DROPPED;
      return res;
    end

    // Add with clipping to the signed 32-bit range
    sum = longint'(image_copy[idx]) + longint'(it.value);
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      res.saturated = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      res.saturated = 1'b1;
    end
    image_copy[idx] = sum[ValW-1:0];
    res.status = STAT_ADDED;
    return res;
  endfunction

  // Random item: mostly well-formed column elements under the current
  // settings, some reads, the rest raw noise
  function automatic cmd_item_t random_item();
    logic [95:0] noise;
    cmd_item_t   it;
    int          pick;
    int          span;

    noise = {$urandom, $urandom, $urandom};
    it    = noise[$bits(cmd_item_t)-1:0];
    pick  = $urandom_range(0, 99);
    if (pick < 20) begin
      it.cmd = CMD_READ;
      span = int'(regs_copy.image_height) * int'(regs_copy.image_width)
             * int'(regs_copy.channels_in);
      span = (span > StoreDepth) ? StoreDepth : ((span < 1) ? 1 : span);
      if ($urandom_range(0, 3) != 0) begin
        it.read_address = RAddrW'($urandom_range(0, span - 1));
      end
    end else begin
      it.cmd = CMD_ACC;
      if (pick < 90) begin
        if (regs_copy.kernel_size != 0) begin
          it.kernel_row = KernW'($urandom_range(0, regs_copy.kernel_size - 1));
          it.kernel_col = KernW'($urandom_range(0, regs_copy.kernel_size - 1));
        end
        if (regs_copy.channels_in != 0) begin
          it.channel = ChW'($urandom_range(0, (regs_copy.channels_in > 16) ? 15 :
                                              regs_copy.channels_in - 1));
        end
        if (regs_copy.grad_height != 0) begin
          it.out_row = GPosW'($urandom_range(0, (regs_copy.grad_height > 32) ? 31 :
                                                regs_copy.grad_height - 1));
        end
        if (regs_copy.grad_width != 0) begin
          it.out_col = GPosW'($urandom_range(0, (regs_copy.grad_width > 32) ? 31 :
                                                regs_copy.grad_width - 1));
        end
      end
      // value mix: raw, near the rails, or small Q16.16 numbers
      case ($urandom_range(0, 3))
        0: ;
        1: it.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                           : 32'h8000_0000 + $urandom_range(0, 255);
        default: it.value = ValW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
    end
    return it;
  endfunction

  // Offer one item, wait for it to be taken, then note its reply
  task automatic send_item(cmd_item_t it, logic typed_in, reply_t typed_reply);
    reply_t worked_out;

    while ($urandom_range(0, 99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid        <= 1'b1;
    item_ch.cmd          <= it.cmd;
    item_ch.kernel_row   <= it.kernel_row;
    item_ch.kernel_col   <= it.kernel_col;
    item_ch.channel      <= it.channel;
    item_ch.out_row      <= it.out_row;
    item_ch.out_col      <= it.out_col;
    item_ch.value        <= it.value;
    item_ch.read_address <= it.read_address;
    @(posedge clk_i);
    while (item_ch.ready !== 1'b1) @(posedge clk_i);
    worked_out = scatter_item(it);
    replies_due.push_back(typed_in ? typed_reply : worked_out);
  endtask

  // Register write; the copy follows at the same edge
  task automatic write_reg(cfg_reg_e which, logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (which)
      REG_STRIDE:       regs_copy.stride       = data[StrideW-1:0];
      REG_PAD:          regs_copy.pad          = data[PadW-1:0];
      REG_KERNEL_SIZE:  regs_copy.kernel_size  = data[KsW-1:0];
      REG_IMAGE_HEIGHT: regs_copy.image_height = data[DimW-1:0];
      REG_IMAGE_WIDTH:  regs_copy.image_width  = data[DimW-1:0];
      REG_CHANNELS_IN:  regs_copy.channels_in  = data[ChCfgW-1:0];
      REG_GRAD_HEIGHT:  regs_copy.grad_height  = data[DimW-1:0];
      REG_GRAD_WIDTH:   regs_copy.grad_width   = data[DimW-1:0];
      default: ;
    endcase
  endtask

  // Receiver: random back-pressure and in-order checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (reply_ch.valid === 1'b1 && reply_ch.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result item: status %0d read_value %h",
                 reply_ch.status, reply_ch.read_value);
          mismatches++;
        end else begin
          oldest_due = replies_due.pop_front();
          if (reply_ch.status !== oldest_due.status) begin
            $error("status: expected %0d, got %0d", oldest_due.status, reply_ch.status);
            mismatches++;
          end
          if (reply_ch.read_value !== oldest_due.read_value) begin
            $error("read_value: expected %h, got %h",
                   oldest_due.read_value, reply_ch.read_value);
            mismatches++;
          end
          if (reply_ch.saturated !== oldest_due.saturated) begin
            $error("saturated: expected %0d, got %0d",
                   oldest_due.saturated, reply_ch.saturated);
            mismatches++;
          end
        end
      end
      reply_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end else begin
      reply_ch.ready <= 1'b0;
    end
  end

  // Watchdog; allows for the store clearing pass after reset
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL col2im_scatter_accumulate");
      $finish;
    end
  end

  initial begin
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_index_i          <= REG_STRIDE;
    cfg_data_i           <= '0;
    item_ch.valid        <= 1'b0;
    item_ch.cmd          <= CMD_ACC;
    item_ch.kernel_row   <= '0;
    item_ch.kernel_col   <= '0;
    item_ch.channel      <= '0;
    item_ch.out_row      <= '0;
    item_ch.out_col      <= '0;
    item_ch.value        <= '0;
    item_ch.read_address <= '0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    regs_copy            = CfgReset;
    foreach (image_copy[i]) image_copy[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hand-made items at the reset settings
    for (int i = 0; i < NumDirected; i++) begin
      send_item(DirectedRows[i].item, DirectedRows[i].typed_in, DirectedRows[i].reply);
    end
    item_ch.valid <= 1'b0;

    // Random phases, each under its own register settings and idling
    for (int p = 0; p < NumPhases; p++) begin
      while (replies_due.size() != 0) @(posedge clk_i);
      case (PhaseIdle[p])
        IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        IDLE_SENDER:   begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
        IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
        default:       begin sender_idle_pct = 7;  receiver_stall_pct = 7;  end
      endcase
      for (int r = 0; r < NumRegs; r++) begin
        write_reg(cfg_reg_e'(r), PhaseRegs[p][r]);
      end
      cfg_we_i <= 1'b0;
      for (int n = 0; n < PhaseItems[p]; n++) begin
        send_item(random_item(), 1'b0, '0);
      end
      item_ch.valid <= 1'b0;
    end

    // Drain, then a short quiet spell to catch stray result items
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS col2im_scatter_accumulate");
    end else begin
      $display("FAIL col2im_scatter_accumulate");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/c2isa_pkg.sv
hdl/c2isa_if.sv
hdl/c2isa_queue.sv
hdl/c2isa_front.sv
hdl/c2isa_back.sv
hdl/col2im_scatter_accumulate.sv
hdl/c2isa_checker.sv
dv/testbench.sv
